>>> rtl/json_token_lexer_core_defines.svh
// Assertion macros for the JSON token lexer.
// Used only by the top level; no other dependencies.
`ifndef JSON_TOKEN_LEXER_CORE_DEFINES_SVH
`define JSON_TOKEN_LEXER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Check a same-cycle implication.
`define JTL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lexer check failed");
// Check an implication that must hold in the next cycle.
`define JTL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lexer check failed");
`else
`define JTL_ASSERT_NOW(label, clk, rst, ante, cons)
`define JTL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/jtl_pkg.sv
// Shared types, token codes and keyword tables for the JSON token lexer.
// No dependencies.
package jtl_pkg;

   localparam int MAX_FRACTION_DIGITS = 9;
   localparam int QUEUE_DEPTH         = 3;
   localparam int QUEUE_CNT_W         = $clog2(QUEUE_DEPTH + 1);

   localparam logic [30:0] INT_MAX31 = 31'h7FFF_FFFF;

   typedef logic [3:0] kind_type;

   localparam kind_type K_NULL      = 4'd0;
   localparam kind_type K_OBJ_OPEN  = 4'd1;
   localparam kind_type K_OBJ_CLOSE = 4'd2;
   localparam kind_type K_ARR_OPEN  = 4'd3;
   localparam kind_type K_ARR_CLOSE = 4'd4;
   localparam kind_type K_STRBYTE   = 4'd5;
   localparam kind_type K_STREND    = 4'd6;
   localparam kind_type K_INT       = 4'd7;
   localparam kind_type K_DEC       = 4'd8;
   localparam kind_type K_BOOL      = 4'd9;
   localparam kind_type K_COMMA     = 4'd10;
   localparam kind_type K_COLON     = 4'd11;
   localparam kind_type K_ERROR     = 4'd12;
   localparam kind_type K_END       = 4'd13;

   localparam logic [1:0] KW_TRUE  = 2'd0;
   localparam logic [1:0] KW_FALSE = 2'd1;
   localparam logic [1:0] KW_NULL  = 2'd2;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      kind_type    token_kind;
      logic [30:0] integer_part;
      logic [29:0] fraction_digits;
      logic [3:0]  fraction_count;
      logic        truth_value;
      logic [7:0]  string_char;
      logic        overflow_flag;
      logic        last_of_item;
   } rsp_type;

   typedef enum logic [6:0] {
      MODE_IDLE = 7'b0000001,
      MODE_STR  = 7'b0000010,
      MODE_ESC  = 7'b0000100,
      MODE_INT  = 7'b0001000,
      MODE_FRAC = 7'b0010000,
      MODE_KEY  = 7'b0100000,
      MODE_HALT = 7'b1000000
   } mode_type;

   typedef struct packed {
      logic idle;
      logic halted;
   } scan_status_type;

   // Expected letter of a keyword at a position; zero past its end.
   function automatic logic [7:0] kw_char(logic [1:0] which, logic [2:0] pos);
      logic [7:0] ch;
      ch = 8'h00;
      case (which)
         KW_TRUE: begin
            case (pos)
               3'd0: ch = "t";
               3'd1: ch = "r";
               3'd2: ch = "u";
               3'd3: ch = "e";
               default: ch = 8'h00;
            endcase
         end
         KW_FALSE: begin
            case (pos)
               3'd0: ch = "f";
               3'd1: ch = "a";
               3'd2: ch = "l";
               3'd3: ch = "s";
               3'd4: ch = "e";
               default: ch = 8'h00;
            endcase
         end
         KW_NULL: begin
            case (pos)
               3'd0: ch = "n";
               3'd1: ch = "u";
               3'd2: ch = "l";
               3'd3: ch = "l";
               default: ch = 8'h00;
            endcase
         end
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [2:0] kw_len(logic [1:0] which);
      logic [2:0] len;
      case (which)
         KW_FALSE: len = 3'd5;
         default:  len = 3'd4;
      endcase
      return len;
   endfunction

endpackage

>>> rtl/jtl_scan.sv
// Scanner state and per-byte token logic: one request in, up to two results out.
// Depends on jtl_pkg.
module jtl_scan
   import jtl_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  req_type         req,
   output logic [1:0]      push_count,
   output rsp_type         push0,
   output rsp_type         push1,
   output scan_status_type status
);

   mode_type    mode_ff, mode_in;
   logic [30:0] int_acc_ff, int_acc_in;
   logic [29:0] frac_acc_ff, frac_acc_in;
   logic [3:0]  frac_cnt_ff, frac_cnt_in;
   logic [1:0]  kw_which_ff, kw_which_in;
   logic [2:0]  kw_pos_ff, kw_pos_in;
   logic        sat_ff, sat_in;

   logic [7:0]  c;
   logic [3:0]  digit;
   logic        is_ws, is_digit, is_quote, is_kw_start, punct_hit;
   kind_type    punct_kind;
   logic        idle_emit;
   kind_type    idle_kind;
   logic [34:0] int_wide;
   logic [33:0] frac_wide;
   logic [2:0]  kw_next_pos;
   logic        kw_bad;
   logic        flush, use_idle;
   logic        first_v, second_v;
   rsp_type     first_r, second_r, flush_r;
   rsp_type     r0, r1;
   logic [1:0]  cnt;

   assign c        = req.text_byte;
   assign digit    = 4'(c - 8'h30);
   assign is_ws    = c inside {8'h20, [8'h09:8'h0D]};
   assign is_digit = c inside {["0":"9"]};
   assign is_quote = (c == "\"");
   assign is_kw_start = c inside {"t", "f", "n"};

   always_comb begin
      punct_hit  = 1'b1;
      punct_kind = K_ERROR;
      case (c)
         "{":     punct_kind = K_OBJ_OPEN;
         "}":     punct_kind = K_OBJ_CLOSE;
         "[":     punct_kind = K_ARR_OPEN;
         "]":     punct_kind = K_ARR_CLOSE;
         ",":     punct_kind = K_COMMA;
         ":":     punct_kind = K_COLON;
         default: punct_hit  = 1'b0;
      endcase
   end

   // Anything that opens no token and is not skipped is an error.
   assign idle_emit = punct_hit || !(is_ws || is_quote || is_kw_start || is_digit);
   assign idle_kind = punct_hit ? punct_kind : K_ERROR;

   // Times ten by shift and add.
   assign int_wide  = 35'({int_acc_ff, 3'b000}) + 35'({int_acc_ff, 1'b0}) + 35'(digit);
   assign frac_wide = 34'({frac_acc_ff, 3'b000}) + 34'({frac_acc_ff, 1'b0}) + 34'(digit);

   assign kw_next_pos = kw_pos_ff + 3'd1;
   assign kw_bad      = (kw_which_ff == 2'd3) || (c != kw_char(kw_which_ff, kw_pos_ff));

   always_comb begin
      flush_r                 = '0;
      flush_r.token_kind      = (mode_ff == MODE_FRAC) ? K_DEC : K_INT;
      flush_r.integer_part    = int_acc_ff;
      flush_r.fraction_digits = (mode_ff == MODE_FRAC) ? frac_acc_ff : '0;
      flush_r.fraction_count  = (mode_ff == MODE_FRAC) ? frac_cnt_ff : '0;
      flush_r.overflow_flag   = sat_ff;
   end

   always_comb begin
      mode_in     = mode_ff;
      int_acc_in  = int_acc_ff;
      frac_acc_in = frac_acc_ff;
      frac_cnt_in = frac_cnt_ff;
      kw_which_in = kw_which_ff;
      kw_pos_in   = kw_pos_ff;
      sat_in      = sat_ff;
      first_v     = 1'b0;
      first_r     = '0;
      second_v    = 1'b0;
      second_r    = '0;
      flush       = 1'b0;
      use_idle    = 1'b0;

      if (req.end_of_text) begin
         if (mode_ff == MODE_INT || mode_ff == MODE_FRAC) begin
            first_v = 1'b1;
            first_r = flush_r;
         end else if (mode_ff == MODE_STR || mode_ff == MODE_ESC || mode_ff == MODE_KEY) begin
            first_v            = 1'b1;
            first_r.token_kind = K_ERROR;
         end
         second_v            = 1'b1;
         second_r.token_kind = K_END;
         mode_in     = MODE_IDLE;
         int_acc_in  = '0;
         frac_acc_in = '0;
         frac_cnt_in = '0;
         kw_which_in = '0;
         kw_pos_in   = '0;
         sat_in      = 1'b0;
      end else begin
         case (mode_ff)
            MODE_IDLE: use_idle = 1'b1;
            MODE_STR: begin
               if (is_quote) begin
                  second_v            = 1'b1;
                  second_r.token_kind = K_STREND;
                  mode_in             = MODE_IDLE;
               end else if (c == "\\") begin
                  mode_in = MODE_ESC;
               end else begin
                  second_v             = 1'b1;
                  second_r.token_kind  = K_STRBYTE;
                  second_r.string_char = c;
               end
            end
            MODE_ESC: begin
               second_v             = 1'b1;
               second_r.token_kind  = K_STRBYTE;
               second_r.string_char = c;
               mode_in              = MODE_STR;
            end
            MODE_INT: begin
               if (is_digit) begin
                  if (int_wide > 35'(INT_MAX31)) begin
                     int_acc_in = INT_MAX31;
                     sat_in     = 1'b1;
                  end else begin
                     int_acc_in = int_wide[30:0];
                  end
               end else if (c == ".") begin
                  mode_in = MODE_FRAC;
               end else begin
                  flush    = 1'b1;
                  use_idle = 1'b1;
               end
            end
            MODE_FRAC: begin
               if (is_digit) begin
                  if (frac_cnt_ff < 4'(MAX_FRACTION_DIGITS)) begin
                     frac_acc_in = frac_wide[29:0];
                     frac_cnt_in = frac_cnt_ff + 4'd1;
                  end else begin
                     sat_in = 1'b1;
                  end
               end else begin
                  flush    = 1'b1;
                  use_idle = 1'b1;
               end
            end
            MODE_KEY: begin
               if (kw_bad) begin
                  second_v            = 1'b1;
                  second_r.token_kind = K_ERROR;
                  mode_in             = MODE_HALT;
               end else if (kw_next_pos >= kw_len(kw_which_ff)) begin
                  second_v = 1'b1;
                  if (kw_which_ff == KW_NULL) begin
                     second_r.token_kind = K_NULL;
                  end else begin
                     second_r.token_kind  = K_BOOL;
                     second_r.truth_value = (kw_which_ff == KW_TRUE);
                  end
                  kw_which_in = '0;
                  kw_pos_in   = '0;
                  mode_in     = MODE_IDLE;
               end else begin
                  kw_pos_in = kw_next_pos;
               end
            end
            MODE_HALT: mode_in = MODE_HALT;
            default:   mode_in = MODE_HALT;
         endcase

         // Emit the pending number, then treat the byte as between tokens.
         if (flush) begin
            first_v     = 1'b1;
            first_r     = flush_r;
            int_acc_in  = '0;
            frac_acc_in = '0;
            frac_cnt_in = '0;
            sat_in      = 1'b0;
            mode_in     = MODE_IDLE;
         end
         if (use_idle) begin
            second_v            = idle_emit;
            second_r.token_kind = idle_kind;
            if (idle_emit && !punct_hit) begin
               mode_in = MODE_HALT;
            end else if (is_quote) begin
               mode_in = MODE_STR;
            end else if (is_kw_start) begin
               mode_in     = MODE_KEY;
               kw_pos_in   = 3'd1;
               kw_which_in = (c == "t") ? KW_TRUE : ((c == "f") ? KW_FALSE : KW_NULL);
            end else if (is_digit) begin
               mode_in     = MODE_INT;
               int_acc_in  = 31'(digit);
               frac_acc_in = '0;
               frac_cnt_in = '0;
               sat_in      = 1'b0;
            end
         end
      end
   end

   // Pack the results in order and mark the last one.
   always_comb begin
      if (first_v) begin
         r0  = first_r;
         r1  = second_r;
         cnt = second_v ? 2'd2 : 2'd1;
      end else begin
         r0  = second_r;
         r1  = '0;
         cnt = second_v ? 2'd1 : 2'd0;
      end
      if (cnt == 2'd2) begin
         r1.last_of_item = 1'b1;
      end else begin
         r0.last_of_item = 1'b1;
      end
   end

   assign push_count    = accept ? cnt : 2'd0;
   assign push0         = r0;
   assign push1         = r1;
   assign status.idle   = (mode_ff == MODE_IDLE);
   assign status.halted = (mode_ff == MODE_HALT);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         int_acc_ff  <= '0;
         frac_acc_ff <= '0;
         frac_cnt_ff <= '0;
         kw_which_ff <= '0;
         kw_pos_ff   <= '0;
         sat_ff      <= 1'b0;
      end else if (accept) begin
         mode_ff     <= mode_in;
         int_acc_ff  <= int_acc_in;
         frac_acc_ff <= frac_acc_in;
         frac_cnt_ff <= frac_cnt_in;
         kw_which_ff <= kw_which_in;
         kw_pos_ff   <= kw_pos_in;
         sat_ff      <= sat_in;
      end
   end

endmodule

>>> rtl/jtl_rsp_queue.sv
// Short result queue: takes up to two results a cycle, hands out one.
// Depends on jtl_pkg.
module jtl_rsp_queue
   import jtl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] push_count,
   input  rsp_type    push0,
   input  rsp_type    push1,
   output logic       room_for_two,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_payload
);

   rsp_type                q_ff [QUEUE_DEPTH];
   rsp_type                q_in [QUEUE_DEPTH];
   rsp_type                shifted [QUEUE_DEPTH];
   logic [QUEUE_CNT_W-1:0] count_ff, count_in, base;
   logic                   pop;

   assign rsp_valid    = (count_ff != '0);
   assign rsp_payload  = q_ff[0];
   assign pop          = rsp_valid && rsp_ready;
   assign room_for_two = (count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
   assign base         = count_ff - QUEUE_CNT_W'(pop);
   assign count_in     = base + QUEUE_CNT_W'(push_count);

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
         shifted[i] = pop ? q_ff[i + 1] : q_ff[i];
      end
      shifted[QUEUE_DEPTH - 1] = q_ff[QUEUE_DEPTH - 1];
   end

   // Advance the head, then write new results behind what remains.
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (push_count != 2'd0 && QUEUE_CNT_W'(i) == base) begin
            q_in[i] = push0;
         end else if (push_count == 2'd2 && QUEUE_CNT_W'(i) == base + QUEUE_CNT_W'(1)) begin
            q_in[i] = push1;
         end else begin
            q_in[i] = shifted[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

>>> rtl/json_token_lexer_core.sv
// JSON token lexer: one text byte per request, up to two tokens per request.
// A token is registered in the result queue when its request is taken and is
// offered once those ahead have gone. Throughput: one request per cycle while
// each gives at most one token and rsp_ready is high; a two-token request stalls.
// A three-entry result queue parts the two sides. Synchronous reset empties
// the queue and returns the scanner to idle between tokens.
`include "json_token_lexer_core_defines.svh"
module json_token_lexer_core
   import jtl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic            accept;
   logic [1:0]      push_count;
   rsp_type         push0, push1;
   scan_status_type status;
   logic            room_for_two;
   logic            end_taken, halted_byte;

   assign req_ready   = room_for_two;
   assign accept      = req_valid && req_ready;
   assign end_taken   = accept && req_payload.end_of_text;
   assign halted_byte = accept && !req_payload.end_of_text && status.halted;

   jtl_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req        (req_payload),
      .push_count (push_count),
      .push0      (push0),
      .push1      (push1),
      .status     (status)
   );

   jtl_rsp_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push_count   (push_count),
      .push0        (push0),
      .push1        (push1),
      .room_for_two (room_for_two),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload)
   );

   `JTL_ASSERT_NEXT(a_end_returns_idle, clock, reset, end_taken, status.idle)
   `JTL_ASSERT_NOW(a_halt_is_silent, clock, reset, halted_byte, push_count == 2'd0)
   `JTL_ASSERT_NOW(a_end_gives_token, clock, reset, end_taken, push_count != 2'd0)
   `JTL_ASSERT_NOW(a_no_push_unaccepted, clock, reset, !accept, push_count == 2'd0)

endmodule
